// ----- hw/rtl/nsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_pkg
// Types, constants and saturation helpers of the nine-slice quad generator.
// ----------------------------------------------------------------------------
package nsq_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [16:0] ONE_UV = 17'd65536;

	// configuration register indexes
	localparam logic [2:0] REG_ATLAS_START_U   = 3'd0;
	localparam logic [2:0] REG_ATLAS_START_V   = 3'd1;
	localparam logic [2:0] REG_ATLAS_SIZE_U    = 3'd2;
	localparam logic [2:0] REG_ATLAS_SIZE_V    = 3'd3;
	localparam logic [2:0] REG_ORIGINAL_WIDTH  = 3'd4;
	localparam logic [2:0] REG_ORIGINAL_HEIGHT = 3'd5;

	localparam logic [1:0] SEG_LO  = 2'd0;
	localparam logic [1:0] SEG_MID = 2'd1;
	localparam logic [1:0] SEG_HI  = 2'd2;

	// UV borders, wide enough for the unsaturated sums
	typedef logic signed [20:0] uv_t;
	// screen positions and sizes before saturation
	typedef logic signed [26:0] scr_t;

	typedef struct packed {
		logic [16:0] start_u;
		logic [16:0] start_v;
		logic [16:0] size_u;
		logic [16:0] size_v;
		logic [22:0] orig_w;
		logic [22:0] orig_h;
	} cfg_t;

	typedef struct packed {
		logic signed [23:0] screen_x;
		logic signed [23:0] screen_y;
		logic [22:0] screen_w;
		logic [22:0] screen_h;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [16:0] tex_u_width;
		logic [16:0] tex_v_height;
		logic [16:0] margin_left;
		logic [16:0] margin_top;
		logic [16:0] margin_right;
		logic [16:0] margin_bottom;
	} req_t;

	typedef struct packed {
		logic signed [23:0] pos;
		logic [22:0] size;
		logic [16:0] t;
		logic [16:0] tw;
		logic [16:0] ma;
		logic [16:0] mb;
		logic [16:0] start;
		logic [16:0] ext;
		logic [22:0] orig;
	} axis_in_t;

	typedef struct packed {
		logic cropped;
		uv_t  t0;
		uv_t  m1;
		uv_t  m2;
		uv_t  t3;
		scr_t p0;
		scr_t p1;
		scr_t p2;
		scr_t s_lo;
		scr_t s_mid;
		scr_t s_hi;
	} axis_res_t;

	typedef struct packed {
		axis_res_t ax;
		axis_res_t ay;
	} job_t;

	typedef enum logic [2:0] {
		AX_IDLE,
		AX_PROD,
		AX_CROP,
		AX_DIV,
		AX_SCALE,
		AX_MAP,
		AX_DONE
	} axis_state_t;

	localparam scr_t SCR_HI = 27'sd8388607;
	localparam scr_t SCR_LO = -27'sd8388608;
	localparam uv_t  UV_HI  = 21'sd65536;
	localparam uv_t  UV_LO  = -21'sd65536;

	function automatic logic [23:0] sat_scr(scr_t v);
		return (v > SCR_HI) ? 24'h7FFFFF : ((v < SCR_LO) ? 24'h800000 : v[23:0]);
	endfunction

	function automatic logic [16:0] sat_uv(uv_t v);
		return (v < 21'sd0) ? 17'd0 : ((v > UV_HI) ? ONE_UV : v[16:0]);
	endfunction

	function automatic logic [17:0] sat_uvw(uv_t v);
		return (v > UV_HI) ? 18'h10000 : ((v < UV_LO) ? 18'h30000 : v[17:0]);
	endfunction

endpackage

// ----- hw/rtl/nsq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_if
// Request, quad and configuration channels of the nine-slice quad generator.
// ----------------------------------------------------------------------------
interface nsq_req_if;
	logic valid;
	logic ready;
	logic signed [23:0] screen_x;
	logic signed [23:0] screen_y;
	logic [22:0] screen_w;
	logic [22:0] screen_h;
	logic [16:0] tex_u;
	logic [16:0] tex_v;
	logic [16:0] tex_u_width;
	logic [16:0] tex_v_height;
	logic [16:0] margin_left;
	logic [16:0] margin_top;
	logic [16:0] margin_right;
	logic [16:0] margin_bottom;

	modport source(output valid, screen_x, screen_y, screen_w, screen_h, tex_u, tex_v,
		tex_u_width, tex_v_height, margin_left, margin_top, margin_right, margin_bottom,
		input ready);
	modport sink(input valid, screen_x, screen_y, screen_w, screen_h, tex_u, tex_v,
		tex_u_width, tex_v_height, margin_left, margin_top, margin_right, margin_bottom,
		output ready);
endinterface

interface nsq_quad_if;
	logic valid;
	logic ready;
	logic [3:0] slice_part;
	logic signed [23:0] quad_x;
	logic signed [23:0] quad_y;
	logic signed [23:0] quad_w;
	logic signed [23:0] quad_h;
	logic [16:0] quad_u;
	logic [16:0] quad_v;
	logic signed [17:0] quad_u_width;
	logic signed [17:0] quad_v_height;
	logic last_quad;

	modport source(output valid, slice_part, quad_x, quad_y, quad_w, quad_h, quad_u, quad_v,
		quad_u_width, quad_v_height, last_quad, input ready);
	modport sink(input valid, slice_part, quad_x, quad_y, quad_w, quad_h, quad_u, quad_v,
		quad_u_width, quad_v_height, last_quad, output ready);
endinterface

interface nsq_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] addr;
	logic [22:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/nsq_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_axis
// One slicing axis: atlas borders, margin shrink by a bit-serial divider,
// and screen positions and sizes of the three segments.
// ----------------------------------------------------------------------------
module nsq_axis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  nsq_pkg::axis_in_t  ax_in,
	input  logic               ack,
	output logic               ready,
	output logic               done,
	output nsq_pkg::axis_res_t res
);
	import nsq_pkg::*;

	axis_state_t state_q, state_nxt;
	axis_in_t    in_q;
	axis_res_t   res_q;

	logic [24:0] minsz_q;
	logic [23:0] sa_q, sb_q;
	uv_t         t0_q, t3_q;
	logic [17:0] twe_q;
	logic        cropped_q;
	logic [24:0] rem_q;
	logic [4:0]  bit_q;
	logic [16:0] keep_q;
	logic [16:0] mak_q, mbk_q;
	logic [23:0] slo_q, shi_q;

	logic [17:0] msum;
	logic [40:0] minsz_prod;
	logic [39:0] sa_prod, sb_prod;
	logic [33:0] t_prod, tw_prod;
	logic        div_need;
	logic [25:0] trial;
	logic        trial_ge;
	logic [33:0] mak_prod, mbk_prod;
	logic [40:0] slo_prod, shi_prod;
	logic [33:0] m1_prod;
	logic signed [17:0] inner;
	logic signed [35:0] m2_prod;
	logic [35:0] m2_mag;
	logic [19:0] m2_q;
	logic signed [20:0] m2_tz;

	assign msum       = {1'b0, in_q.ma} + {1'b0, in_q.mb};
	assign minsz_prod = 41'(in_q.orig) * 41'(msum);
	assign sa_prod    = 40'(in_q.orig) * 40'(in_q.ma);
	assign sb_prod    = 40'(in_q.orig) * 40'(in_q.mb);
	assign t_prod     = 34'(in_q.t) * 34'(in_q.ext);
	assign tw_prod    = 34'(in_q.tw) * 34'(in_q.ext);

	assign div_need = ({2'b0, in_q.size} <= minsz_q) && (minsz_q != 25'd0);

	// restoring division step; the low dividend bits past size[0] are zero
	assign trial    = {rem_q, (bit_q == 5'd16) ? in_q.size[0] : 1'b0};
	assign trial_ge = trial >= {1'b0, minsz_q};

	assign mak_prod = 34'(in_q.ma) * 34'(keep_q);
	assign mbk_prod = 34'(in_q.mb) * 34'(keep_q);
	assign slo_prod = 41'(sa_q) * 41'(keep_q);
	assign shi_prod = 41'(sb_q) * 41'(keep_q);

	assign m1_prod = 34'(mak_q) * 34'(in_q.ext);
	assign inner   = 18'sd65536 - $signed({1'b0, mbk_q});
	assign m2_prod = 36'(inner) * $signed({19'b0, in_q.ext});
	// truncate toward zero
	assign m2_mag  = m2_prod[35] ? 36'(-m2_prod) : 36'(m2_prod);
	assign m2_q    = m2_mag[35:16];
	assign m2_tz   = m2_prod[35] ? -$signed({1'b0, m2_q}) : $signed({1'b0, m2_q});

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			AX_IDLE:  if (start) state_nxt = AX_PROD;
			AX_PROD:  state_nxt = AX_CROP;
			AX_CROP:  state_nxt = div_need ? AX_DIV : AX_SCALE;
			AX_DIV:   if (bit_q == 5'd0) state_nxt = AX_SCALE;
			AX_SCALE: state_nxt = AX_MAP;
			AX_MAP:   state_nxt = AX_DONE;
			AX_DONE: begin
				if (ack) state_nxt = start ? AX_PROD : AX_IDLE;
			end
			default:  state_nxt = AX_IDLE;
		endcase
	end

	always_comb begin
		done  = 1'b0;
		ready = 1'b0;
		unique case (state_q)
			AX_IDLE: ready = 1'b1;
			AX_DONE: begin
				done  = 1'b1;
				ready = ack;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= AX_IDLE;
		else         state_q <= state_nxt;
	end

	always_ff @(posedge clk) begin
		if (start && ready) in_q <= ax_in;
		case (state_q)
			AX_PROD: begin
				minsz_q <= minsz_prod[40:16];
				sa_q    <= sa_prod[39:16];
				sb_q    <= sb_prod[39:16];
				t0_q    <= uv_t'({4'b0, in_q.start}) + uv_t'({3'b0, t_prod[33:16]});
				twe_q   <= tw_prod[33:16];
			end
			AX_CROP: begin
				cropped_q <= {2'b0, in_q.size} <= minsz_q;
				rem_q     <= {3'b0, in_q.size[22:1]};
				bit_q     <= 5'd16;
				keep_q    <= div_need ? 17'd0 : ONE_UV;
			end
			AX_DIV: begin
				if (trial_ge) begin
					rem_q         <= 25'(trial - {1'b0, minsz_q});
					keep_q[bit_q] <= 1'b1;
				end else begin
					rem_q <= trial[24:0];
				end
				bit_q <= bit_q - 5'd1;
			end
			AX_SCALE: begin
				mak_q <= mak_prod[32:16];
				mbk_q <= mbk_prod[32:16];
				slo_q <= slo_prod[39:16];
				shi_q <= shi_prod[39:16];
				t3_q  <= t0_q + uv_t'({3'b0, twe_q});
			end
			AX_MAP: begin
				res_q.cropped <= cropped_q;
				res_q.t0      <= t0_q;
				res_q.t3      <= t3_q;
				res_q.m1      <= uv_t'({4'b0, in_q.start}) + uv_t'({3'b0, m1_prod[33:16]});
				res_q.m2      <= uv_t'({4'b0, in_q.start}) + m2_tz;
				res_q.p0      <= scr_t'(in_q.pos);
				res_q.p1      <= scr_t'(in_q.pos) + scr_t'({3'b0, slo_q});
				res_q.p2      <= scr_t'(in_q.pos) + scr_t'({4'b0, in_q.size})
					- scr_t'({3'b0, shi_q});
				res_q.s_lo    <= scr_t'({3'b0, slo_q});
				res_q.s_hi    <= scr_t'({3'b0, shi_q});
				res_q.s_mid   <= scr_t'({4'b0, in_q.size})
					- (scr_t'({3'b0, sa_q}) + scr_t'({3'b0, sb_q}));
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

// ----- hw/rtl/nsq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_front
// Accepts request words, runs both axis units and hands finished jobs on.
// ----------------------------------------------------------------------------
module nsq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  nsq_pkg::cfg_t  cfg,
	nsq_req_if.sink        req,
	input  logic           q_full,
	output logic           push,
	output nsq_pkg::job_t  job
);
	import nsq_pkg::*;

	req_t      buf_q;
	logic      buf_v_q;
	axis_in_t  in_x, in_y;
	axis_res_t res_x, res_y;
	logic      rdy_x, rdy_y, done_x, done_y;
	logic      start, ack, take;

	assign req.ready = !buf_v_q;
	assign take      = req.valid && !buf_v_q;
	assign ack       = done_x && done_y && !q_full;
	assign start     = buf_v_q && rdy_x && rdy_y;
	assign push      = ack;
	assign job       = '{ax: res_x, ay: res_y};

	assign in_x = '{pos: buf_q.screen_x, size: buf_q.screen_w, t: buf_q.tex_u,
		tw: buf_q.tex_u_width, ma: buf_q.margin_left, mb: buf_q.margin_right,
		start: cfg.start_u, ext: cfg.size_u, orig: cfg.orig_w};
	assign in_y = '{pos: buf_q.screen_y, size: buf_q.screen_h, t: buf_q.tex_v,
		tw: buf_q.tex_v_height, ma: buf_q.margin_top, mb: buf_q.margin_bottom,
		start: cfg.start_v, ext: cfg.size_v, orig: cfg.orig_h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_v_q <= 1'b0;
		end else if (take) begin
			buf_v_q <= 1'b1;
		end else if (start) begin
			buf_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= '{screen_x: req.screen_x, screen_y: req.screen_y,
				screen_w: req.screen_w, screen_h: req.screen_h,
				tex_u: req.tex_u, tex_v: req.tex_v,
				tex_u_width: req.tex_u_width, tex_v_height: req.tex_v_height,
				margin_left: req.margin_left, margin_top: req.margin_top,
				margin_right: req.margin_right, margin_bottom: req.margin_bottom};
		end
	end

	nsq_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ax_in  (in_x),
		.ack    (ack),
		.ready  (rdy_x),
		.done   (done_x),
		.res    (res_x)
	);

	nsq_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ax_in  (in_y),
		.ack    (ack),
		.ready  (rdy_y),
		.done   (done_y),
		.res    (res_y)
	);

endmodule

// ----- hw/rtl/nsq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_queue
// Short job queue between the front and the quad emitter.
// ----------------------------------------------------------------------------
module nsq_queue #(
	parameter int DEPTH = nsq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nsq_pkg::job_t wr_data,
	output logic          full,
	input  logic          pop,
	output nsq_pkg::job_t rd_data,
	output logic          empty
);
	import nsq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- hw/rtl/nsq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_back
// Walks the rows and columns of a job and emits one saturated quad per word.
// ----------------------------------------------------------------------------
module nsq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  nsq_pkg::job_t job,
	input  logic          job_valid,
	output logic          pop,
	nsq_quad_if.source    quad
);
	import nsq_pkg::*;

	logic [1:0] row_q, col_q;
	logic       out_v_q;
	logic       load, last, col_wrap;
	logic [1:0] col_nxt, row_nxt;
	scr_t       x, y, w, h;
	uv_t        u, v, uw, vh;

	logic [3:0]         part_q;
	logic signed [23:0] x_q, y_q, w_q, h_q;
	logic [16:0]        u_q, v_q;
	logic signed [17:0] uw_q, vh_q;
	logic               last_q;

	assign load     = job_valid && (!out_v_q || quad.ready);
	assign last     = (row_q == SEG_HI) && (col_q == SEG_HI);
	assign col_wrap = col_q == SEG_HI;
	// skip the centre column or row when that axis is cropped
	assign col_nxt  = col_wrap ? SEG_LO :
		((col_q == SEG_LO && job.ax.cropped) ? SEG_HI : col_q + 2'd1);
	assign row_nxt  = (row_q == SEG_LO && job.ay.cropped) ? SEG_HI : row_q + 2'd1;
	assign pop      = load && last;

	always_comb begin
		case (col_q)
			SEG_MID: begin
				x = job.ax.p1; w = job.ax.s_mid; u = job.ax.m1; uw = job.ax.m2 - job.ax.m1;
			end
			SEG_HI: begin
				x = job.ax.p2; w = job.ax.s_hi; u = job.ax.m2; uw = job.ax.t3 - job.ax.m2;
			end
			default: begin
				x = job.ax.p0; w = job.ax.s_lo; u = job.ax.t0; uw = job.ax.m1 - job.ax.t0;
			end
		endcase
		case (row_q)
			SEG_MID: begin
				y = job.ay.p1; h = job.ay.s_mid; v = job.ay.m1; vh = job.ay.m2 - job.ay.m1;
			end
			SEG_HI: begin
				y = job.ay.p2; h = job.ay.s_hi; v = job.ay.m2; vh = job.ay.t3 - job.ay.m2;
			end
			default: begin
				y = job.ay.p0; h = job.ay.s_lo; v = job.ay.t0; vh = job.ay.m1 - job.ay.t0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= SEG_LO;
			col_q   <= SEG_LO;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				col_q   <= col_nxt;
				if (col_wrap) row_q <= last ? SEG_LO : row_nxt;
			end else if (quad.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			part_q <= 4'({row_q, 1'b0} + row_q) + 4'(col_q);
			x_q    <= sat_scr(x);
			y_q    <= sat_scr(y);
			w_q    <= sat_scr(w);
			h_q    <= sat_scr(h);
			u_q    <= sat_uv(u);
			v_q    <= sat_uv(v);
			uw_q   <= sat_uvw(uw);
			vh_q   <= sat_uvw(vh);
			last_q <= last;
		end
	end

	assign quad.valid         = out_v_q;
	assign quad.slice_part    = part_q;
	assign quad.quad_x        = x_q;
	assign quad.quad_y        = y_q;
	assign quad.quad_w        = w_q;
	assign quad.quad_h        = h_q;
	assign quad.quad_u        = u_q;
	assign quad.quad_v        = v_q;
	assign quad.quad_u_width  = uw_q;
	assign quad.quad_v_height = vh_q;
	assign quad.last_quad     = last_q;

endmodule

// ----- hw/rtl/nine_slice_quad_generator.sv -----
`timescale 1ns / 1ps
// A request word passes the front buffer, the axis unit sequencers (products, crop,
// the 17-step divider when a margin shrink is needed, scale, map) and the job queue
// before the output register presents its first quad. The front buffer takes another
// request while the axis units still work; the quad emitter gives up to nine quad
// words per job, fewer when an axis is cropped.
// Reset: asynchronous, clears handshakes, queue and sequencers; atlas window
// returns to start 0, size 1.0, original size 0.
// ----------------------------------------------------------------------------
// nine_slice_quad_generator
// Nine-slice quad generator: maps a request into up to nine screen/UV quads.
// ----------------------------------------------------------------------------
module nine_slice_quad_generator #(
	parameter int QUEUE_DEPTH = nsq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nsq_cfg_if.sink    cfg,
	nsq_req_if.sink    req,
	nsq_quad_if.source quad
);
	import nsq_pkg::*;

	cfg_t cfg_q;
	job_t job_wr, job_rd;
	logic push, pop, q_full, q_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{start_u: 17'd0, start_v: 17'd0, size_u: ONE_UV, size_v: ONE_UV,
				orig_w: 23'd0, orig_h: 23'd0};
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_ATLAS_START_U:   cfg_q.start_u <= cfg.data[16:0];
				REG_ATLAS_START_V:   cfg_q.start_v <= cfg.data[16:0];
				REG_ATLAS_SIZE_U:    cfg_q.size_u  <= cfg.data[16:0];
				REG_ATLAS_SIZE_V:    cfg_q.size_v  <= cfg.data[16:0];
				REG_ORIGINAL_WIDTH:  cfg_q.orig_w  <= cfg.data;
				REG_ORIGINAL_HEIGHT: cfg_q.orig_h  <= cfg.data;
				default: ;
			endcase
		end
	end

	nsq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.job    (job_wr)
	);

	nsq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job_wr),
		.full    (q_full),
		.pop     (pop),
		.rd_data (job_rd),
		.empty   (q_empty)
	);

	nsq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_rd),
		.job_valid (!q_empty),
		.pop       (pop),
		.quad      (quad)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("job pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("job popped from empty queue");

	a_last_is_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(quad.valid && quad.last_quad) |-> (quad.slice_part == 4'd8))
		else $error("last quad is not the bottom right slice");

endmodule
